FILE: design/cvtee_pkg.sv
package cvtee_pkg;

    localparam int HISTORY_DEPTH = 4;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int LEVEL_WIDTH   = 15;
    localparam int HOLD_WIDTH    = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = HOLD_WIDTH;

    // Comparison width holds a sample or a level plus one carry and one sign bit.
    localparam int CMP_WIDTH =
        ((SAMPLE_WIDTH > LEVEL_WIDTH + 1) ? SAMPLE_WIDTH : LEVEL_WIDTH + 1) + 2;

    localparam logic [HOLD_WIDTH-1:0]  RST_HOLDOFF_TIME = HOLD_WIDTH'(10);
    localparam logic [LEVEL_WIDTH-1:0] RST_ABS_LEVEL    = LEVEL_WIDTH'(1024);
    localparam logic [LEVEL_WIDTH-1:0] RST_REL_LEVEL    = LEVEL_WIDTH'(819);
    localparam logic [LEVEL_WIDTH-1:0] RST_SAME_THR     = LEVEL_WIDTH'(819);
    localparam logic [LEVEL_WIDTH-1:0] RST_OPP_THR      = LEVEL_WIDTH'(614);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_HOLDOFF_TIME = 3'd0,
        CFG_ABS_LEVEL    = 3'd1,
        CFG_REL_LEVEL    = 3'd2,
        CFG_SAME_THR     = 3'd3,
        CFG_OPP_THR      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_HOLD      = 3'd1,
        EV_RISE_HIGH = 3'd2,
        EV_RISE_LOW  = 3'd3,
        EV_RISE_MID  = 3'd4,
        EV_FALL_HIGH = 3'd5,
        EV_FALL_LOW  = 3'd6,
        EV_FALL_MID  = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        GATE_IDLE = 3'b001,
        GATE_HIGH = 3'b010,
        GATE_LOW  = 3'b100
    } t_gate;

endpackage

FILE: design/cv_trigger_event_extractor_top.sv
// Flow: a sample accepted into the input register has its event code loaded into the
// result register once the result register can advance, and then shown on the outputs.
// Throughput: one sample per cycle; the input register and the result register
// form a two-stage flow that stalls its input only when both stages are full and
// the result is held.
// Reset (synchronous, active low) restores the register defaults, clears the
// sample history and hold-off count, sets the gate idle and empties both stages.
module cv_trigger_event_extractor_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [cvtee_pkg::SAMPLE_WIDTH-1:0] i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic        [2:0]                      o_event_code,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [cvtee_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic        [cvtee_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);

    localparam int SW = cvtee_pkg::SAMPLE_WIDTH;
    localparam int LW = cvtee_pkg::LEVEL_WIDTH;
    localparam int HW = cvtee_pkg::HOLD_WIDTH;
    localparam int CW = cvtee_pkg::CMP_WIDTH;
    localparam int HD = cvtee_pkg::HISTORY_DEPTH;

    logic [HW-1:0] r_holdoff_time;
    logic [LW-1:0] r_abs_level;
    logic [LW-1:0] r_rel_level;
    logic [LW-1:0] r_same_thr;
    logic [LW-1:0] r_opp_thr;

    logic                 r_in_valid;
    logic signed [SW-1:0] r_sample;
    logic                 r_out_valid;
    cvtee_pkg::t_event    r_out_code;

    logic signed [SW-1:0] r_hist [HD];
    cvtee_pkg::t_gate     r_gate;
    logic [HW-1:0]        r_holdoff;

    cvtee_pkg::t_event    n_code;
    cvtee_pkg::t_gate     n_gate;
    logic [HW-1:0]        n_holdoff;

    logic advance;
    logic step;
    logic in_accept;

    logic signed [CW-1:0] x_w;
    logic signed [CW-1:0] old_w;
    logic signed [CW-1:0] abs_w;
    logic signed [CW-1:0] rel_w;
    logic signed [CW-1:0] same_w;
    logic signed [CW-1:0] opp_w;

    assign advance     = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_event_code = r_out_code;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_time <= cvtee_pkg::RST_HOLDOFF_TIME;
            r_abs_level    <= cvtee_pkg::RST_ABS_LEVEL;
            r_rel_level    <= cvtee_pkg::RST_REL_LEVEL;
            r_same_thr     <= cvtee_pkg::RST_SAME_THR;
            r_opp_thr      <= cvtee_pkg::RST_OPP_THR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cvtee_pkg::CFG_HOLDOFF_TIME: r_holdoff_time <= i_cfg_data[HW-1:0];
                cvtee_pkg::CFG_ABS_LEVEL:    r_abs_level    <= i_cfg_data[LW-1:0];
                cvtee_pkg::CFG_REL_LEVEL:    r_rel_level    <= i_cfg_data[LW-1:0];
                cvtee_pkg::CFG_SAME_THR:     r_same_thr     <= i_cfg_data[LW-1:0];
                cvtee_pkg::CFG_OPP_THR:      r_opp_thr      <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign x_w    = {{(CW-SW){r_sample[SW-1]}}, r_sample};
    assign old_w  = {{(CW-SW){r_hist[0][SW-1]}}, r_hist[0]};
    assign abs_w  = {{(CW-LW){1'b0}}, r_abs_level};
    assign rel_w  = {{(CW-LW){1'b0}}, r_rel_level};
    assign same_w = {{(CW-LW){1'b0}}, r_same_thr};
    assign opp_w  = {{(CW-LW){1'b0}}, r_opp_thr};

    always_comb begin
        n_code    = cvtee_pkg::EV_NONE;
        n_gate    = r_gate;
        n_holdoff = r_holdoff;
        priority if (r_holdoff != '0) begin
            n_holdoff = r_holdoff - HW'(1);
            n_code    = cvtee_pkg::EV_HOLD;
        end else if (r_gate == cvtee_pkg::GATE_IDLE) begin
            priority if (x_w > old_w + rel_w && x_w >= abs_w) begin
                priority if (old_w > same_w) begin
                    n_code = cvtee_pkg::EV_RISE_HIGH;
                end else if (old_w < -opp_w) begin
                    n_code = cvtee_pkg::EV_RISE_LOW;
                end else begin
                    n_code = cvtee_pkg::EV_RISE_MID;
                end
                n_gate    = cvtee_pkg::GATE_HIGH;
                n_holdoff = r_holdoff_time;
            end else if (x_w < old_w - rel_w && x_w <= -abs_w) begin
                priority if (old_w > opp_w) begin
                    n_code = cvtee_pkg::EV_FALL_HIGH;
                end else if (old_w < -same_w) begin
                    n_code = cvtee_pkg::EV_FALL_LOW;
                end else begin
                    n_code = cvtee_pkg::EV_FALL_MID;
                end
                n_gate    = cvtee_pkg::GATE_LOW;
                n_holdoff = r_holdoff_time;
            end else begin
                n_code = cvtee_pkg::EV_NONE;
            end
        end else begin
            priority if (x_w < abs_w && x_w > -abs_w) begin
                n_code    = cvtee_pkg::EV_NONE;
                n_gate    = cvtee_pkg::GATE_IDLE;
                n_holdoff = r_holdoff_time;
            end else begin
                n_code = cvtee_pkg::EV_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_gate      <= cvtee_pkg::GATE_IDLE;
            r_holdoff   <= '0;
            for (int i = 0; i < HD; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_gate    <= n_gate;
                r_holdoff <= n_holdoff;
                for (int i = 0; i < HD - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[HD-1] <= r_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample;
        end
        if (step) begin
            r_out_code <= n_code;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_holdoff != '0 |=> r_out_valid && r_out_code == cvtee_pkg::EV_HOLD)
        else $error("hold-off running but result is not hold");

    a_holdoff_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_holdoff != '0 |=> r_holdoff == $past(r_holdoff) - HW'(1))
        else $error("hold-off counter did not count down");

    a_gate_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_gate) && $stable(r_holdoff))
        else $error("gate state changed without a request");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled while a stage is empty");
`endif

endmodule

FILE: tb/cv_trigger_event_extractor_top_tb.sv
`timescale 1ns / 100ps

module cv_trigger_event_extractor_top_tb;

    localparam int SW  = cvtee_pkg::SAMPLE_WIDTH;
    localparam int HD  = cvtee_pkg::HISTORY_DEPTH;
    localparam int LW  = cvtee_pkg::LEVEL_WIDTH;
    localparam int HW  = cvtee_pkg::HOLD_WIDTH;
    localparam int IW  = cvtee_pkg::CFG_IDX_WIDTH;
    localparam int DW  = cvtee_pkg::CFG_DATA_WIDTH;

    localparam int SAMPLE_MAX      = 2 ** (SW - 1) - 1;
    localparam int SAMPLE_MIN      = -(2 ** (SW - 1));
    localparam int PHASES          = 10;
    localparam int SAMPLES_PER_PHASE = 110;
    localparam int LONG_HOLD       = 64;
    localparam int QUIET_LIMIT     = 2000;
    localparam logic [IW-1:0] CFG_IDX_UNUSED = cvtee_pkg::CFG_OPP_THR + 3'd1;

    typedef struct {
        logic                     is_write;
        logic [IW-1:0]            reg_index;
        logic [DW-1:0]            reg_value;
        logic signed [SW-1:0]     sample;
        logic                     typed;
        cvtee_pkg::t_event        typed_code;
    } t_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic signed [SW-1:0]             i_sample = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [2:0]                       o_event_code;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [IW-1:0]                    i_cfg_index = '0;
    logic [DW-1:0]                    i_cfg_data = '0;

    // Predicted block state and register copies.
    logic signed [SW-1:0]             recent_samples [HD];
    cvtee_pkg::t_gate                 gate_pred = cvtee_pkg::GATE_IDLE;
    logic [HW-1:0]                    holdoff_left = '0;
    logic [HW-1:0]                    holdoff_time = cvtee_pkg::RST_HOLDOFF_TIME;
    logic [LW-1:0]                    abs_level = cvtee_pkg::RST_ABS_LEVEL;
    logic [LW-1:0]                    rel_level = cvtee_pkg::RST_REL_LEVEL;
    logic [LW-1:0]                    same_thr = cvtee_pkg::RST_SAME_THR;
    logic [LW-1:0]                    opp_thr = cvtee_pkg::RST_OPP_THR;

    cvtee_pkg::t_event                expected_events [$];
    t_row                             directed_rows [$];
    int                               failures = 0;
    int                               samples_sent = 0;
    int                               events_seen = 0;
    int                               code_hits [8];
    int                               sender_idle_pct = 0;
    int                               receiver_stall_pct = 0;
    int                               hold_requests = 0;
    int                               holds_served = 0;
    int                               quiet_cycles = 0;

    cv_trigger_event_extractor_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_code (o_event_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        foreach (recent_samples[k]) recent_samples[k] = '0;
        foreach (code_hits[k]) code_hits[k] = 0;
    end

    function automatic cvtee_pkg::t_event step_gate(input logic signed [SW-1:0] x);
        int                xv;
        int                oldv;
        int                absl;
        int                relv;
        int                same;
        int                opp;
        int                k;
        cvtee_pkg::t_event code;
        xv = int'(x);
        oldv = int'(recent_samples[0]);
        absl = int'(abs_level);
        relv = int'(rel_level);
        same = int'(same_thr);
        opp = int'(opp_thr);
        if (holdoff_left != 0) begin
            holdoff_left = holdoff_left - 1'b1;
            code = cvtee_pkg::EV_HOLD;
        end else if (gate_pred == cvtee_pkg::GATE_IDLE) begin
            if (xv > oldv + relv && xv >= absl) begin
                if (oldv > same) code = cvtee_pkg::EV_RISE_HIGH;
                else if (oldv < -opp) code = cvtee_pkg::EV_RISE_LOW;
                else code = cvtee_pkg::EV_RISE_MID;
                gate_pred = cvtee_pkg::GATE_HIGH;
                holdoff_left = holdoff_time;
            end else if (xv < oldv - relv && xv <= -absl) begin
                if (oldv > opp) code = cvtee_pkg::EV_FALL_HIGH;
                else if (oldv < -same) code = cvtee_pkg::EV_FALL_LOW;
                else code = cvtee_pkg::EV_FALL_MID;
                gate_pred = cvtee_pkg::GATE_LOW;
                holdoff_left = holdoff_time;
            end else begin
                code = cvtee_pkg::EV_NONE;
            end
        end else if (xv < absl && xv > -absl) begin
            code = cvtee_pkg::EV_NONE;
            gate_pred = cvtee_pkg::GATE_IDLE;
            holdoff_left = holdoff_time;
        end else begin
            code = cvtee_pkg::EV_HOLD;
        end
        for (k = 0; k < HD - 1; k++) recent_samples[k] = recent_samples[k + 1];
        recent_samples[HD - 1] = x;
        return code;
    endfunction

    // Samples cluster around the trigger, release and classification boundaries.
    function automatic logic signed [SW-1:0] pick_sample();
        int oldv;
        int absl;
        int relv;
        int e;
        int v;
        oldv = int'(recent_samples[0]);
        absl = int'(abs_level);
        relv = int'(rel_level);
        e = $urandom_range(0, 4);
        e = e - 2;
        case ($urandom_range(0, 11))
            0, 1: v = int'($signed(SW'($urandom)));
            2, 3: begin
                v = (oldv + relv + 1 > absl) ? oldv + relv + 1 : absl;
                v = v + e;
            end
            4, 5: begin
                v = (oldv - relv - 1 < -absl) ? oldv - relv - 1 : -absl;
                v = v - e;
            end
            6: v = oldv + relv + int'($urandom_range(0, 6000));
            7: v = oldv - relv - int'($urandom_range(0, 6000));
            8: v = ($urandom_range(0, 1) ? absl : -absl) + e;
            9: begin
                v = $urandom_range(0, 1) ? int'(same_thr) : int'(opp_thr);
                v = ($urandom_range(0, 1) ? v : -v) + e / 2;
            end
            default: v = int'($urandom_range(0, 2 * absl)) - absl;
        endcase
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return SW'(v);
    endfunction

    function automatic logic [DW-1:0] random_level();
        if ($urandom_range(0, 3) == 0) return DW'($urandom);
        return DW'($urandom_range(0, 3000));
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] s, input logic typed,
                               input cvtee_pkg::t_event code);
        cvtee_pkg::t_event predicted;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = step_gate(s);
        expected_events.push_back(typed ? code : predicted);
        samples_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IW-1:0] idx, input logic [DW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            cvtee_pkg::CFG_HOLDOFF_TIME: holdoff_time = value;
            cvtee_pkg::CFG_ABS_LEVEL:    abs_level = value[LW-1:0];
            cvtee_pkg::CFG_REL_LEVEL:    rel_level = value[LW-1:0];
            cvtee_pkg::CFG_SAME_THR:     same_thr = value[LW-1:0];
            cvtee_pkg::CFG_OPP_THR:      opp_thr = value[LW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [DW-1:0] hold_v,
                             input logic [DW-1:0] abs_v,
                             input logic [DW-1:0] rel_v,
                             input logic [DW-1:0] same_v,
                             input logic [DW-1:0] opp_v);
        write_register(cvtee_pkg::CFG_HOLDOFF_TIME, hold_v);
        write_register(cvtee_pkg::CFG_ABS_LEVEL, abs_v);
        write_register(cvtee_pkg::CFG_REL_LEVEL, rel_v);
        write_register(cvtee_pkg::CFG_SAME_THR, same_v);
        write_register(cvtee_pkg::CFG_OPP_THR, opp_v);
        if ($urandom_range(0, 1))
            write_register(CFG_IDX_UNUSED + IW'($urandom_range(0, 2)), DW'($urandom));
    endtask

    task automatic row_sample(input int s, input logic typed, input cvtee_pkg::t_event code);
        t_row r;
        r.is_write = 1'b0;
        r.reg_index = '0;
        r.reg_value = '0;
        r.sample = SW'(s);
        r.typed = typed;
        r.typed_code = code;
        directed_rows.push_back(r);
    endtask

    task automatic row_write(input logic [IW-1:0] idx, input logic [DW-1:0] value);
        t_row r;
        r.is_write = 1'b1;
        r.reg_index = idx;
        r.reg_value = value;
        r.sample = '0;
        r.typed = 1'b0;
        r.typed_code = cvtee_pkg::EV_NONE;
        directed_rows.push_back(r);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cvtee_pkg::t_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            events_seen++;
            code_hits[o_event_code]++;
            if (expected_events.size() == 0) begin
                $error("event_code: no request pending, got %0d", o_event_code);
                failures++;
            end else begin
                want = expected_events.pop_front();
                if (o_event_code !== want) begin
                    $error("event_code: expected %0d, got %0d", want, o_event_code);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        row_write(cvtee_pkg::CFG_HOLDOFF_TIME, '0);
        row_write(CFG_IDX_UNUSED, '1);
        row_sample(0, 1'b1, cvtee_pkg::EV_NONE);
        row_sample(SAMPLE_MAX, 1'b1, cvtee_pkg::EV_RISE_MID);
        row_sample(int'(cvtee_pkg::RST_ABS_LEVEL), 1'b1, cvtee_pkg::EV_HOLD);
        row_sample(-1024, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(1023, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(SAMPLE_MIN, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(-1023, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(SAMPLE_MAX, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(1024, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(-1024, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(-2000, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(-2000, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(-2000, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(2000, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(0, 1'b0, cvtee_pkg::EV_NONE);
        row_sample(4000, 1'b0, cvtee_pkg::EV_NONE);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_write) begin
                wait_idle();
                write_register(directed_rows[k].reg_index, directed_rows[k].reg_value);
            end else begin
                send_sample(directed_rows[k].sample, directed_rows[k].typed,
                            directed_rows[k].typed_code);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: configure('0, DW'(cvtee_pkg::RST_ABS_LEVEL), DW'(cvtee_pkg::RST_REL_LEVEL),
                             DW'(cvtee_pkg::RST_SAME_THR), DW'(cvtee_pkg::RST_OPP_THR));
                1: configure(16'd3, '0, '0, '0, '0);
                2: configure(16'd1, '1, '1, '1, '1);
                PHASES - 1: configure('1, random_level(), random_level(), random_level(),
                                      random_level());
                default: configure(DW'($urandom_range(0, 12)), random_level(),
                                   random_level(), random_level(), random_level());
            endcase
            sender_idle_pct = (phase % 4 == 1) ? 53 : (phase % 4 == 3) ? 34 : 0;
            receiver_stall_pct = (phase % 4 == 2) ? 53 : (phase % 4 == 3) ? 34 : 0;
            if (phase == 0) hold_requests++;
            repeat (SAMPLES_PER_PHASE) send_sample(pick_sample(), 1'b0, cvtee_pkg::EV_NONE);
        end
        wait_idle();

        $display("Run covered %0d samples and %0d event codes over %0d register settings.",
                 samples_sent, events_seen, PHASES + 1);
        $display("Codes none/hold/rise h,l,m/fall h,l,m: %0d %0d %0d %0d %0d %0d %0d %0d",
                 code_hits[cvtee_pkg::EV_NONE], code_hits[cvtee_pkg::EV_HOLD],
                 code_hits[cvtee_pkg::EV_RISE_HIGH], code_hits[cvtee_pkg::EV_RISE_LOW],
                 code_hits[cvtee_pkg::EV_RISE_MID], code_hits[cvtee_pkg::EV_FALL_HIGH],
                 code_hits[cvtee_pkg::EV_FALL_LOW], code_hits[cvtee_pkg::EV_FALL_MID]);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/cvtee_pkg.sv
design/cv_trigger_event_extractor_top.sv
tb/cv_trigger_event_extractor_top_tb.sv
